// ===== rtl/cpba_pkg.sv =====
// Package for the cluster page bump allocator.
// Word types, per-cluster entry layout, operation/status codes and FSM states.
// No dependencies.
package cpba_pkg;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_BIG   = 2'd1;
  localparam logic [1:0] OP_SMALL = 2'd2;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_MISALIGNED = 2'd1;
  localparam logic [1:0] STAT_NO_PAGES   = 2'd2;

  localparam int unsigned BigShift = 21;
  localparam int unsigned XPos     = 24;
  localparam int unsigned YPos     = 20;
  localparam int unsigned BigPos   = 9;
  localparam logic [9:0]  SlotsPerBig = 10'd512;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  cluster_x;
    logic [1:0]  cluster_y;
    logic [31:0] segment_base;
    logic [31:0] segment_size;
    logic [10:0] page_count;
  } in_word_t;

  typedef struct packed {
    logic [31:0] page_number;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [11:0] next_big_index;
    logic [11:0] limit_big_index;
    logic [10:0] next_small_index;
    logic [9:0]  small_window_limit;
    logic [11:0] small_home_big_index;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // update result handed from the update logic to the controller
  typedef struct packed {
    logic      wr_en;
    entry_t    entry;
    out_word_t result;
  } upd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

endpackage

// ===== rtl/cpba_mem.sv =====
// Per-cluster entry store: one write port, one read port, registered read data.
// Depends on cpba_pkg for the entry type.
module cpba_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  cpba_pkg::entry_t     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output cpba_pkg::entry_t     rd_data_o
);

  cpba_pkg::entry_t mem_q [DEPTH];
  cpba_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/cpba_update.sv =====
// Update logic: applies one request word to one cluster entry and forms the result.
// Depends on cpba_pkg for word, entry and code definitions.
module cpba_update (
  input  cpba_pkg::in_word_t req_i,
  input  logic               in_grid_i,
  input  cpba_pkg::entry_t   entry_i,
  output cpba_pkg::upd_t     upd_o
);

  logic        misaligned;
  logic [32:0] seg_end;
  logic [11:0] init_next;
  logic [12:0] big_sum;
  logic [11:0] small_sum;
  logic [12:0] bump_sum;
  logic        need_page;
  logic [11:0] home_sel;
  logic [10:0] small_sel;
  logic [11:0] page_big;
  logic [10:0] page_small;
  logic [31:0] page;
  logic        zero_cluster;

  always_comb begin
    misaligned   = (|req_i.segment_base[20:0]) || (|req_i.segment_size[20:0]);
    seg_end      = {1'b0, req_i.segment_base} + {1'b0, req_i.segment_size};
    zero_cluster = (req_i.cluster_x == 2'd0) && (req_i.cluster_y == 2'd0);
    init_next    = {1'b0, req_i.segment_base[31:cpba_pkg::BigShift]};
    if (zero_cluster) begin
      init_next = init_next + 12'd1;
    end

    big_sum   = {1'b0, entry_i.next_big_index} + {2'b0, req_i.page_count};
    small_sum = {1'b0, entry_i.next_small_index} + {1'b0, req_i.page_count};
    bump_sum  = {1'b0, entry_i.next_big_index} + 13'd1;
    need_page = small_sum > {2'b0, entry_i.small_window_limit};
    home_sel  = need_page ? entry_i.next_big_index : entry_i.small_home_big_index;
    small_sel = need_page ? 11'd0 : entry_i.next_small_index;

    upd_o.wr_en         = 1'b0;
    upd_o.entry         = entry_i;
    upd_o.result.status = cpba_pkg::STAT_OK;
    page_big            = 12'd0;
    page_small          = 11'd0;
    page                = 32'd0;

    if (!in_grid_i) begin
      if (req_i.operation != cpba_pkg::OP_UNDEF) begin
        upd_o.result.status = cpba_pkg::STAT_NO_PAGES;
      end
    end else begin
      unique case (req_i.operation)
        cpba_pkg::OP_INIT: begin
          if (misaligned) begin
            upd_o.result.status = cpba_pkg::STAT_MISALIGNED;
          end else begin
            upd_o.wr_en                    = 1'b1;
            upd_o.entry.next_big_index     = init_next;
            upd_o.entry.limit_big_index    = seg_end[32:cpba_pkg::BigShift];
            upd_o.entry.next_small_index   = 11'd0;
            upd_o.entry.small_window_limit = 10'd0;
          end
        end
        cpba_pkg::OP_BIG: begin
          if (big_sum > {1'b0, entry_i.limit_big_index}) begin
            upd_o.result.status = cpba_pkg::STAT_NO_PAGES;
          end else begin
            upd_o.wr_en                = 1'b1;
            upd_o.entry.next_big_index = big_sum[11:0];
            page_big                   = entry_i.next_big_index;
            page = {6'd0, req_i.cluster_x, 24'd0} + {10'd0, req_i.cluster_y, 20'd0}
                 + {11'd0, page_big, 9'd0};
          end
        end
        cpba_pkg::OP_SMALL: begin
          if (req_i.page_count > {1'b0, cpba_pkg::SlotsPerBig}) begin
            upd_o.result.status = cpba_pkg::STAT_NO_PAGES;
          end else if (need_page && (bump_sum > {1'b0, entry_i.limit_big_index})) begin
            upd_o.result.status = cpba_pkg::STAT_NO_PAGES;
          end else begin
            upd_o.wr_en = 1'b1;
            if (need_page) begin
              upd_o.entry.small_home_big_index = entry_i.next_big_index;
              upd_o.entry.next_big_index       = bump_sum[11:0];
              upd_o.entry.small_window_limit   = cpba_pkg::SlotsPerBig;
            end
            upd_o.entry.next_small_index = small_sel + req_i.page_count;
            page_big   = home_sel;
            page_small = small_sel;
            page = {6'd0, req_i.cluster_x, 24'd0} + {10'd0, req_i.cluster_y, 20'd0}
                 + {11'd0, page_big, 9'd0} + {21'd0, page_small};
          end
        end
        default: begin
          // undefined operation: ignored, ok status
        end
      endcase
    end

    upd_o.result.page_number = page;
  end

endmodule

// ===== rtl/cluster_page_bump_allocator.sv =====
// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  in_data_i  (cpba_pkg::in_word_t)
// out      out_valid_o/out_ready_i out_data_o (cpba_pkg::out_word_t)
//
// Each word is handled as an entry memory read in ST_IDLE, then as update and
// write-back into the single-port-per-direction entry memory in ST_READ.
// After reset a clearing pass zeroes all X_CLUSTERS*Y_CLUSTERS memory entries,
// with in_ready_o low. The output register lets a new word be taken while a
// result waits; the update stalls while the output register is still full.
// Top level; depends on cpba_pkg, cpba_mem, cpba_update.
module cluster_page_bump_allocator #(
  parameter int unsigned X_CLUSTERS = 4,
  parameter int unsigned Y_CLUSTERS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpba_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpba_pkg::out_word_t out_data_o
);

  localparam int unsigned Depth   = X_CLUSTERS * Y_CLUSTERS;
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  cpba_pkg::state_e    state_q, state_d;
  logic [IdxW-1:0]     clr_q, clr_d;
  cpba_pkg::in_word_t  req_q;
  logic [IdxW-1:0]     idx_q;
  logic                out_valid_q;
  cpba_pkg::out_word_t out_data_q;

  logic [IdxW-1:0]     in_idx;
  logic                in_grid;
  logic                rd_en;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  cpba_pkg::entry_t    wr_data;
  cpba_pkg::entry_t    rd_data;
  cpba_pkg::upd_t      upd;
  logic                out_load;
  logic                accept;

  assign in_idx = IdxW'(int'(in_data_i.cluster_x) * Y_CLUSTERS + int'(in_data_i.cluster_y));
  assign in_grid = ({7'd0, req_q.cluster_x} < 9'(X_CLUSTERS))
                && ({3'd0, req_q.cluster_y} < 5'(Y_CLUSTERS));
  assign accept = in_valid_i && in_ready_o;

  cpba_mem #(
    .DEPTH  (Depth),
    .ADDR_W (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (in_idx),
    .rd_data_o (rd_data)
  );

  cpba_update u_update (
    .req_i     (req_q),
    .in_grid_i (in_grid),
    .entry_i   (rd_data),
    .upd_o     (upd)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = upd.entry;
    out_load   = 1'b0;
    unique case (state_q)
      cpba_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        if (clr_q == LastIdx) begin
          state_d = cpba_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      cpba_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rd_en   = 1'b1;
          state_d = cpba_pkg::ST_READ;
        end
      end
      cpba_pkg::ST_READ: begin
        // write back only when the result can be parked
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          wr_en    = upd.wr_en;
          state_d  = cpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpba_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
      idx_q <= in_idx;
    end
    if (out_load) begin
      out_data_q <= upd.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
